[sv/shbf_pkg.sv]
// ----------------------------------------------------------------------------
// shbf_pkg
// shared types and constants of the shifted harmonic bond force core
// ----------------------------------------------------------------------------
package shbf_pkg;

  localparam int DEF_NUM_BOND_TYPES = 2;
  localparam int SQRT_STEPS         = 32;
  localparam int DIV_STEPS          = 48;
  localparam int CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K0  = 3'd0,
    REG_R00 = 3'd1,
    REG_R10 = 3'd2,
    REG_K1  = 3'd3,
    REG_R01 = 3'd4,
    REG_R11 = 3'd5
  } cfg_reg_t;

  // running state of the square root chain
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_st_t;

  // bond data carried alongside the square root chain
  typedef struct packed {
    logic [2:0][31:0] dmag;
    logic [2:0]       dneg;
    logic [31:0]      k;
    logic [31:0]      r0;
    logic [63:0]      ssq;
    logic             we;
  } sqrt_side_t;

  // running state of one divider lane
  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] bits;
    logic [47:0] q;
  } div_st_t;

  // bond data carried alongside the divider chain
  typedef struct packed {
    logic [31:0] r;
    logic [2:0]  fneg;
    logic [2:0]  big;
    logic        rzero;
    logic [62:0] emag;
    logic        eneg;
    logic        we;
  } div_side_t;

endpackage

[sv/shbf_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// shbf_sqrt_cell
// one digit step of the integer square root chain
// ----------------------------------------------------------------------------
module shbf_sqrt_cell import shbf_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  sqrt_st_t   in_st,
  input  sqrt_side_t in_side,
  output logic       out_valid_r,
  output sqrt_st_t   out_st_r,
  output sqrt_side_t out_side_r
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  sqrt_st_t    st_nxt;

  always_comb begin
    trial = in_st.res + BIT;
    if (in_st.v >= trial) begin
      st_nxt.v   = in_st.v - trial;
      st_nxt.res = (in_st.res >> 1) + BIT;
    end else begin
      st_nxt.v   = in_st.v;
      st_nxt.res = in_st.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r   <= st_nxt;
      out_side_r <= in_side;
    end
  end

endmodule

[sv/shbf_div_cell.sv]
// ----------------------------------------------------------------------------
// shbf_div_cell
// one quotient bit of the three force dividers
// ----------------------------------------------------------------------------
module shbf_div_cell import shbf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  div_st_t [2:0]  in_st,
  input  div_side_t      in_side,
  output logic           out_valid_r,
  output div_st_t [2:0]  out_st_r,
  output div_side_t      out_side_r
);

  logic [32:0]   t [3];
  div_st_t [2:0] st_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t[a] = {in_st[a].rem, in_st[a].bits[47]};
      st_nxt[a].bits = {in_st[a].bits[46:0], 1'b0};
      if (t[a] >= {1'b0, in_side.r}) begin
        st_nxt[a].rem = 32'(t[a] - {1'b0, in_side.r});
        st_nxt[a].q   = {in_st[a].q[46:0], 1'b1};
      end else begin
        st_nxt[a].rem = t[a][31:0];
        st_nxt[a].q   = {in_st[a].q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r   <= st_nxt;
      out_side_r <= in_side;
    end
  end

endmodule

[sv/shifted_harmonic_bond_force_core.sv]
// ----------------------------------------------------------------------------
// shifted_harmonic_bond_force_core
// per-bond shifted harmonic force and energy, Q16.16, saturated to 48 bits
// ----------------------------------------------------------------------------
// pipeline: 2 front stages, 32 square root cells, 5 arithmetic stages
//   (A to E), 48 divider cells and 1 output register
// throughput: one bond per cycle; the whole chain stalls only while a
//   result waits in the output register and out_tready is low
// reset: rst_n synchronous active low clears all valid bits and zeroes
//   the coefficient registers
module shifted_harmonic_bond_force_core import shbf_pkg::*; #(
  parameter int NUM_BOND_TYPES = DEF_NUM_BOND_TYPES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // bond input: tdata = disp_x, disp_y, disp_z (lowest first)
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,
  // tuser = bond_kind, want_energy (lowest first)
  input  logic [1:0]           in_tuser,
  // result: tdata = force_x, force_y, force_z, bond_energy (lowest first)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [191:0]         out_tdata,
  // tuser = overflow_flag
  output logic                 out_tuser,
  // coefficient register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // global advance: every stage moves when the output slot can take a result
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // coefficient registers
  logic [31:0] k_r [2];
  logic [31:0] r0_r [2];
  logic [31:0] r1_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 2; t++) begin
        k_r[t]  <= '0;
        r0_r[t] <= '0;
        r1_r[t] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_K0:  k_r[0]  <= cfg_data;
        REG_R00: r0_r[0] <= cfg_data;
        REG_R10: r1_r[0] <= cfg_data;
        REG_K1:  k_r[1]  <= cfg_data;
        REG_R01: r0_r[1] <= cfg_data;
        REG_R11: r1_r[1] <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------- stage 1: magnitudes, squares, coefficient select
  logic        kind;
  logic [31:0] d_in [3];
  logic [31:0] mag_in [3];
  logic [32:0] sh_diff;

  logic              s1_valid_r;
  logic [2:0][31:0]  s1_dmag_r;
  logic [2:0]        s1_dneg_r;
  logic [63:0]       s1_sq_r [3];
  logic [31:0]       s1_k_r, s1_r0_r, s1_shmag_r;
  logic              s1_we_r;

  always_comb begin
    kind = (NUM_BOND_TYPES > 1) ? in_tuser[0] : 1'b0;
    for (int a = 0; a < 3; a++) begin
      d_in[a]   = in_tdata[a*32 +: 32];
      mag_in[a] = d_in[a][31] ? 32'(-d_in[a]) : d_in[a];
    end
    sh_diff = {1'b0, r0_r[kind]} - {1'b0, r1_r[kind]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_dmag_r[a] <= mag_in[a];
        s1_dneg_r[a] <= d_in[a][31];
        s1_sq_r[a]   <= 64'(mag_in[a]) * 64'(mag_in[a]);
      end
      s1_k_r     <= k_r[kind];
      s1_r0_r    <= r0_r[kind];
      s1_shmag_r <= sh_diff[32] ? 32'(-sh_diff) : sh_diff[31:0];
      s1_we_r    <= in_tuser[1];
    end
  end

  // ---------------- stage 2: sum of squares, squared energy shift
  logic       s2_valid_r;
  sqrt_st_t   s2_st_r;
  sqrt_side_t s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_st_r.v        <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      s2_st_r.res      <= '0;
      s2_side_r.dmag   <= s1_dmag_r;
      s2_side_r.dneg   <= s1_dneg_r;
      s2_side_r.k      <= s1_k_r;
      s2_side_r.r0     <= s1_r0_r;
      s2_side_r.ssq    <= 64'(s1_shmag_r) * 64'(s1_shmag_r);
      s2_side_r.we     <= s1_we_r;
    end
  end

  // ---------------- square root chain, one result bit per cell
  logic       sq_valid [SQRT_STEPS+1];
  sqrt_st_t   sq_st    [SQRT_STEPS+1];
  sqrt_side_t sq_side  [SQRT_STEPS+1];

  assign sq_valid[0] = s2_valid_r;
  assign sq_st[0]    = s2_st_r;
  assign sq_side[0]  = s2_side_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    shbf_sqrt_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (sq_valid[i]),
      .in_st      (sq_st[i]),
      .in_side    (sq_side[i]),
      .out_valid_r(sq_valid[i+1]),
      .out_st_r   (sq_st[i+1]),
      .out_side_r (sq_side[i+1])
    );
  end

  sqrt_side_t sq_end;
  assign sq_end = sq_side[SQRT_STEPS];

  // ---------------- stage A: dr = r - r0, magnitudes and signs
  logic [31:0] r_root;
  logic [32:0] dr;
  assign r_root = sq_st[SQRT_STEPS].res[31:0];
  assign dr     = {1'b0, r_root} - {1'b0, sq_end.r0};

  logic             sa_valid_r;
  logic [31:0]      sa_r_r, sa_drmag_r, sa_kmag_r;
  logic             sa_drneg_r, sa_kneg_r;
  logic [2:0][31:0] sa_dmag_r;
  logic [2:0]       sa_dneg_r;
  logic [63:0]      sa_ssq_r;
  logic             sa_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (en) begin
      sa_valid_r <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r_r     <= r_root;
      sa_drmag_r <= dr[32] ? 32'(-dr) : dr[31:0];
      sa_drneg_r <= dr[32];
      sa_kmag_r  <= sq_end.k[31] ? 32'(-sq_end.k) : sq_end.k;
      sa_kneg_r  <= sq_end.k[31];
      sa_dmag_r  <= sq_end.dmag;
      sa_dneg_r  <= sq_end.dneg;
      sa_ssq_r   <= sq_end.ssq;
      sa_we_r    <= sq_end.we;
    end
  end

  // ---------------- stage B: k*|dr| and dr^2
  logic             sb_valid_r;
  logic [63:0]      sb_kd_r, sb_dsq_r, sb_ssq_r;
  logic [31:0]      sb_r_r, sb_kmag_r;
  logic             sb_drneg_r, sb_kneg_r, sb_we_r;
  logic [2:0][32:0] sb_m_r;
  logic [2:0]       sb_dneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (en) begin
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_kd_r    <= 64'(sa_kmag_r) * 64'(sa_drmag_r);
      sb_dsq_r   <= 64'(sa_drmag_r) * 64'(sa_drmag_r);
      sb_ssq_r   <= sa_ssq_r;
      sb_r_r     <= sa_r_r;
      sb_kmag_r  <= sa_kmag_r;
      sb_drneg_r <= sa_drneg_r;
      sb_kneg_r  <= sa_kneg_r;
      sb_we_r    <= sa_we_r;
      sb_dneg_r  <= sa_dneg_r;
      for (int a = 0; a < 3; a++) begin
        sb_m_r[a] <= {sa_dmag_r[a], 1'b0};
      end
    end
  end

  // ---------------- stage C: partial products of the force numerator, energy difference
  logic             sc_valid_r;
  logic [63:0]      sc_p0_r [3];
  logic [63:0]      sc_p1_r [3];
  logic [63:0]      sc_kd_r, sc_diff_r;
  logic [2:0]       sc_mh_r;
  logic             sc_diffneg_r;
  logic [31:0]      sc_r_r, sc_kmag_r;
  logic [2:0]       sc_fneg_r;
  logic             sc_kneg_r, sc_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (en) begin
      sc_valid_r <= sb_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sc_p0_r[a]   <= 64'(sb_kd_r[31:0]) * 64'(sb_m_r[a][31:0]);
        sc_p1_r[a]   <= 64'(sb_kd_r[63:32]) * 64'(sb_m_r[a][31:0]);
        sc_mh_r[a]   <= sb_m_r[a][32];
        // force on first atom points against k*dr*d
        sc_fneg_r[a] <= !(sb_kneg_r ^ sb_drneg_r ^ sb_dneg_r[a]);
      end
      sc_kd_r      <= sb_kd_r;
      sc_diffneg_r <= sb_dsq_r < sb_ssq_r;
      sc_diff_r    <= (sb_dsq_r < sb_ssq_r) ? sb_ssq_r - sb_dsq_r : sb_dsq_r - sb_ssq_r;
      sc_r_r       <= sb_r_r;
      sc_kmag_r    <= sb_kmag_r;
      sc_kneg_r    <= sb_kneg_r;
      sc_we_r      <= sb_we_r;
    end
  end

  // ---------------- stage D: numerator sum, energy partial products
  logic        sd_valid_r;
  logic [95:0] sd_n_r [3];
  logic [63:0] sd_e0_r, sd_e1_r;
  logic        sd_eneg_r;
  logic [31:0] sd_r_r;
  logic [2:0]  sd_fneg_r;
  logic        sd_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_valid_r <= 1'b0;
    end else if (en) begin
      sd_valid_r <= sc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sd_n_r[a] <= {32'd0, sc_p0_r[a]} + {sc_p1_r[a], 32'd0}
                     + (sc_mh_r[a] ? {sc_kd_r, 32'd0} : 96'd0);
      end
      sd_e0_r   <= 64'(sc_kmag_r) * 64'(sc_diff_r[31:0]);
      sd_e1_r   <= 64'(sc_kmag_r) * 64'(sc_diff_r[63:32]);
      sd_eneg_r <= sc_kneg_r ^ sc_diffneg_r;
      sd_r_r    <= sc_r_r;
      sd_fneg_r <= sc_fneg_r;
      sd_we_r   <= sc_we_r;
    end
  end

  // ---------------- stage E: energy magnitude, divider setup
  // quotient of (n >> 16) by r; upper part at or above r means >= 2^48
  logic [95:0]   e_sum;
  logic [79:0]   n_sh [3];
  logic [2:0]    big_nxt;

  always_comb begin
    e_sum = {32'd0, sd_e0_r} + {sd_e1_r, 32'd0};
    for (int a = 0; a < 3; a++) begin
      n_sh[a]    = sd_n_r[a][95:16];
      big_nxt[a] = n_sh[a][79:48] >= sd_r_r;
    end
  end

  logic          se_valid_r;
  div_st_t [2:0] se_st_r;
  div_side_t     se_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_valid_r <= 1'b0;
    end else if (en) begin
      se_valid_r <= sd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        se_st_r[a].rem  <= big_nxt[a] ? 32'd0 : n_sh[a][79:48];
        se_st_r[a].bits <= n_sh[a][47:0];
        se_st_r[a].q    <= '0;
      end
      se_side_r.r     <= sd_r_r;
      se_side_r.fneg  <= sd_fneg_r;
      se_side_r.big   <= big_nxt;
      se_side_r.rzero <= sd_r_r == 32'd0;
      se_side_r.emag  <= e_sum[94:32];
      se_side_r.eneg  <= sd_eneg_r;
      se_side_r.we    <= sd_we_r;
    end
  end

  // ---------------- divider chain, one quotient bit per cell
  logic          dv_valid [DIV_STEPS+1];
  div_st_t [2:0] dv_st    [DIV_STEPS+1];
  div_side_t     dv_side  [DIV_STEPS+1];

  assign dv_valid[0] = se_valid_r;
  assign dv_st[0]    = se_st_r;
  assign dv_side[0]  = se_side_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    shbf_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (dv_valid[i]),
      .in_st      (dv_st[i]),
      .in_side    (dv_side[i]),
      .out_valid_r(dv_valid[i+1]),
      .out_st_r   (dv_st[i+1]),
      .out_side_r (dv_side[i+1])
    );
  end

  // ---------------- output stage: saturation to 48 bits
  div_side_t     ov_side;
  div_st_t [2:0] ov_st;
  logic [47:0]   force_v [3];
  logic [47:0]   energy_v;
  logic          sat_any;
  logic          ovf;
  logic [47:0]   mag48;

  localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

  always_comb begin
    ov_side = dv_side[DIV_STEPS];
    ov_st   = dv_st[DIV_STEPS];
    sat_any = 1'b0;
    ovf     = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mag48 = ov_st[a].q;
      if (ov_side.rzero) begin
        force_v[a] = '0;
      end else if (ov_side.fneg[a]) begin
        ovf = ov_side.big[a] || (mag48[47] && (|mag48[46:0]));
        sat_any = sat_any | ovf;
        force_v[a] = ovf ? NEG_LIM : 48'(-mag48);
      end else begin
        ovf = ov_side.big[a] || mag48[47];
        sat_any = sat_any | ovf;
        force_v[a] = ovf ? POS_LIM : mag48;
      end
    end
    mag48 = ov_side.emag[47:0];
    if (!ov_side.we) begin
      energy_v = '0;
    end else if (ov_side.eneg) begin
      ovf = (|ov_side.emag[62:48]) || (ov_side.emag[47] && (|ov_side.emag[46:0]));
      sat_any = sat_any | ovf;
      energy_v = ovf ? NEG_LIM : 48'(-mag48);
    end else begin
      ovf = (|ov_side.emag[62:47]);
      sat_any = sat_any | ovf;
      energy_v = ovf ? POS_LIM : mag48;
    end
  end

  logic [191:0] out_data_r;
  logic         out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {energy_v, force_v[2], force_v[1], force_v[0]};
      out_flag_r <= sat_any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

endmodule

[sv/shbf_checker.sv]
// ----------------------------------------------------------------------------
// shbf_checker
// port-level checks of the bond force core, bound to the top level
// ----------------------------------------------------------------------------
module shbf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic         out_tuser,
  input logic         cfg_ready
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the output slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty or draining output slot never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready && cfg_ready)
    else $error("input stalled with free output slot");

endmodule

bind shifted_harmonic_bond_force_core shbf_checker u_shbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_ready (cfg_ready)
);

[tb/tb_shifted_harmonic_bond_force_core.sv]
// ----------------------------------------------------------------------------
// tb_shifted_harmonic_bond_force_core
// self-checking bench: streams bonds through the core under several
// coefficient settings, predicts force and energy bit for bit, and checks
// every result transaction in order
// ----------------------------------------------------------------------------

// expected force and energy of one bond, with its saturation flag
typedef struct {
  logic [47:0] fx;
  logic [47:0] fy;
  logic [47:0] fz;
  logic [47:0] energy;
  logic        ovf;
} bond_result_t;

class bond_force_scoreboard;
  // coefficient copy, indexed by bond kind
  logic [31:0]  stiff[2];
  logic [31:0]  rest[2];
  logic [31:0]  zero[2];
  bond_result_t pending_q[$];
  int           n_bonds;
  int           n_results;
  int           n_errors;
  int           n_ovf;
  int           n_energy;

  function void clear_coeffs();
    for (int t = 0; t < 2; t++) begin
      stiff[t] = '0;
      rest[t]  = '0;
      zero[t]  = '0;
    end
  endfunction

  function void write_coeff(logic [2:0] idx, logic [31:0] val);
    int t;
    t = idx / 3;
    if (idx > shbf_pkg::REG_R11) return;  // unused indexes are dropped
    case (idx % 3)
      0: stiff[t] = val;
      1: rest[t]  = val;
      default: zero[t] = val;
    endcase
  endfunction

  // floor square root of a 64-bit value
  function logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // clamp a sign and magnitude to 48-bit signed
  function logic [47:0] clamp48(bit neg, logic [127:0] mag, inout logic ovf);
    logic [127:0] m;
    m = mag;
    if (neg) begin
      if (m > 128'h8000_0000_0000) begin
        ovf = 1'b1;
        m   = 128'h8000_0000_0000;
      end
      m = -m;
    end else if (m > 128'h7FFF_FFFF_FFFF) begin
      ovf = 1'b1;
      m   = 128'h7FFF_FFFF_FFFF;
    end
    return m[47:0];
  endfunction

  function void note_bond(logic [95:0] disp, logic [1:0] flags);
    logic [31:0]  dcomp[3];
    logic [127:0] dmag_ax[3];
    bit           dneg_ax[3];
    logic [63:0]  rsq;
    logic [63:0]  r;
    longint       dr;
    longint       sh;
    logic [127:0] kmag;
    logic [127:0] drmag;
    logic [127:0] prod;
    logic [127:0] dsq;
    logic [127:0] ssq;
    logic [127:0] diff;
    bit           kneg;
    bit           drneg;
    bit           diffneg;
    int           kind;
    bond_result_t res;
    logic [47:0]  f[3];
    rsq = '0;
    for (int a = 0; a < 3; a++) begin
      dcomp[a]   = disp[32*a +: 32];
      dneg_ax[a] = dcomp[a][31];
      dmag_ax[a] = dneg_ax[a] ? 128'(-$signed({1'b1, dcomp[a]})) : 128'(dcomp[a]);
      rsq        = rsq + 64'(dmag_ax[a] * dmag_ax[a]);
    end
    kind  = flags[0];
    kneg  = stiff[kind][31];
    kmag  = kneg ? 128'(-$signed({1'b1, stiff[kind]})) : 128'(stiff[kind]);
    r     = floor_sqrt(rsq);
    dr    = longint'(r) - longint'(rest[kind]);
    drneg = dr < 0;
    drmag = drneg ? 128'(-dr) : 128'(dr);
    res.ovf = 1'b0;
    for (int a = 0; a < 3; a++) begin
      prod = '0;
      if (r != 0) prod = (kmag * drmag * 2 * dmag_ax[a]) / (128'(r) << 16);
      f[a] = clamp48(!(kneg ^ drneg ^ dneg_ax[a]), prod, res.ovf);
    end
    res.fx = f[0];
    res.fy = f[1];
    res.fz = f[2];
    res.energy = '0;
    if (flags[1]) begin
      sh      = longint'(rest[kind]) - longint'(zero[kind]);
      ssq     = (sh < 0 ? 128'(-sh) : 128'(sh));
      ssq     = ssq * ssq;
      dsq     = drmag * drmag;
      diffneg = dsq < ssq;
      diff    = diffneg ? ssq - dsq : dsq - ssq;
      res.energy = clamp48(kneg ^ diffneg, (kmag * diff) >> 32, res.ovf);
      n_energy++;
    end
    if (res.ovf) n_ovf++;
    n_bonds++;
    pending_q.push_back(res);
  endfunction

  function void check_result(logic [191:0] data, logic flag);
    bond_result_t exp_r;
    n_results++;
    if (pending_q.size() == 0) begin
      $error("result transaction with nothing expected: %h", data);
      n_errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (data[47:0] !== exp_r.fx) begin
      $error("force_x exp %h got %h", exp_r.fx, data[47:0]);
      n_errors++;
    end
    if (data[95:48] !== exp_r.fy) begin
      $error("force_y exp %h got %h", exp_r.fy, data[95:48]);
      n_errors++;
    end
    if (data[143:96] !== exp_r.fz) begin
      $error("force_z exp %h got %h", exp_r.fz, data[143:96]);
      n_errors++;
    end
    if (data[191:144] !== exp_r.energy) begin
      $error("bond_energy exp %h got %h", exp_r.energy, data[191:144]);
      n_errors++;
    end
    if (flag !== exp_r.ovf) begin
      $error("overflow_flag exp %b got %b", exp_r.ovf, flag);
      n_errors++;
    end
  endfunction
endclass

module tb_shifted_harmonic_bond_force_core;
  import shbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 88;
  localparam int STALL_LIMIT = 5000;   // cycles with no transaction at all
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  // indexes beyond the coefficient map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [95:0]          in_tdata   = '0;
  logic [1:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [191:0]         out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  bond_force_scoreboard sb = new();

  // sender and receiver behavior knobs
  bit sender_gaps   = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  always #4 clk = ~clk;

  shifted_harmonic_bond_force_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // monitor: values read here are the ones the dut saw at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_bond(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (cfg_valid && cfg_ready) sb.write_coeff(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[shifted_harmonic_bond_force_core] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (receiver_gaps) begin
        out_tready <= ($urandom_range(0, 9) > 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one coefficient write transaction, then cfg_valid is lowered before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one bond transaction; tvalid stays up within a burst
  task automatic send_bond(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic kind, logic we);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {dz, dy, dx};
    in_tuser  <= {we, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait until every expected result is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic load_coeffs(logic [31:0] k0, logic [31:0] a0, logic [31:0] b0,
                             logic [31:0] k1, logic [31:0] a1, logic [31:0] b1);
    write_reg(REG_K0, k0);
    write_reg(REG_R00, a0);
    write_reg(REG_R10, b0);
    write_reg(REG_K1, k1);
    write_reg(REG_R01, a1);
    write_reg(REG_R11, b1);
  endtask

  // displacement mix: mostly physical sizes, some full range and corners
  function automatic logic [31:0] pick_disp();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
    endcase
    return v;
  endfunction

  // coefficients mostly of moderate size, with some full range values
  function automatic logic [31:0] pick_stiff();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
  endfunction

  function automatic logic [31:0] pick_length();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  // length of the last random stretch of a phase
  function automatic int palse_len(int phase);
    return 5 + 2 * phase;
  endfunction

  task automatic random_bonds(int count);
    for (int i = 0; i < count; i++) begin
      send_bond(pick_disp(), pick_disp(), pick_disp(), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    sb.clear_coeffs();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients are zero: every result must be zero
    send_bond(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b1);
    send_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1);
    drain();

    // directed corners with moderate coefficients
    load_coeffs(32'h0002_0000, 32'h0001_0000, 32'h0000_8000,
                32'hFFFD_0000, 32'h0003_0000, 32'h0004_0000);
    write_reg(IDX_SPARE_LO, 32'hDEAD_BEEF);
    write_reg(IDX_SPARE_HI, 32'h1234_5678);
    send_bond(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);               // zero distance
    send_bond(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    send_bond(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b1);       // exactly at rest
    send_bond(32'h0, 32'h0002_0000, 32'h0, 1'b0, 1'b0);
    send_bond(32'h0, 32'h0, 32'hFFFE_0000, 1'b1, 1'b1);
    send_bond(32'h0003_0000, 32'h0004_0000, 32'h0, 1'b1, 1'b0);
    send_bond(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1);
    send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
    send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    send_bond(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_bond(32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_8000, 1'b0, 1'b1);
    drain();

    // extreme coefficients: saturation on both signs
    load_coeffs(32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_bond(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    send_bond(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    send_bond(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1);
    send_bond(32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    send_bond(32'h0000_0001, 32'h0, 32'h0, 1'b1, 1'b0);
    send_bond(32'h0010_0000, 32'hFFF0_0000, 32'h0, 1'b0, 1'b0);
    random_bonds(20);
    drain();

    // random settings; the second one carries the long receiver hold-off
    for (int phase = 0; phase < 6; phase++) begin
      load_coeffs(pick_stiff(), pick_length(), pick_length(),
                  pick_stiff(), pick_length(), pick_length());
      sender_gaps   = (phase != 3);
      receiver_gaps = (phase != 4);
      random_bonds(30);
      if (phase == 1) begin
        hold_req = 1'b1;
        sender_gaps = 1'b0;
      end
      random_bonds(30);
      if (phase == 2) begin
        // sender pauses until everything is back, then carries on
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      random_bonds(palse_len(phase));
      drain();
    end

    $display("bonds %0d, results %0d, energy requests %0d, saturated results %0d",
             sb.n_bonds, sb.n_results, sb.n_energy, sb.n_ovf);
    $display("covered reset, directed corners, extreme and 6 random coefficient sets");
    if (sb.n_errors == 0 && sb.pending_q.size() == 0 && hold_done) begin
      $display("[shifted_harmonic_bond_force_core] OK");
    end else begin
      $display("[shifted_harmonic_bond_force_core] ERROR");
    end
    $finish;
  end

endmodule
